// ===== hw/rtl/mpjq_pkg.sv =====
// Package for the min-priority job queue: slot and chain-carry types,
// request and status codes, sequencer state. No dependencies.
`default_nettype none

package mpjq_pkg;

    localparam logic [1:0] REQ_ENQ  = 2'd0;
    localparam logic [1:0] REQ_DEQ  = 2'd1;
    localparam logic [1:0] REQ_PEEK = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_ZERO  = 2'd2;
    localparam logic [1:0] STATUS_EMPTY = 2'd3;

    typedef struct packed {
        logic [7:0]  pri;
        logic [15:0] pid;
        logic [15:0] job_id;
    } slot_t;

    typedef struct packed {
        logic  found;
        slot_t job;
    } carry_t;

    typedef struct packed {
        logic enq;
        logic shift;
    } cell_ctrl_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mpjq_cell.sv =====
// One queue slot of the min-priority job queue with its stage of the
// minimum-search chain. Depends on mpjq_pkg.
`default_nettype none

module mpjq_cell #(
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  mpjq_pkg::cell_ctrl_t     ctrl,
    input  mpjq_pkg::slot_t          new_job,
    input  wire                      left_busy,
    input  mpjq_pkg::slot_t          right_slot,
    input  wire [IDX_W-1:0]          sel_idx,
    input  mpjq_pkg::carry_t         carry_in,
    input  wire [IDX_W-1:0]          carry_idx_in,
    output mpjq_pkg::carry_t         carry_out,
    output logic [IDX_W-1:0]         carry_idx_out,
    output mpjq_pkg::slot_t          slot
);
    import mpjq_pkg::*;

    slot_t            slot_reg;
    slot_t            slot_next;
    carry_t           carry_reg;
    carry_t           carry_next;
    logic [IDX_W-1:0] cidx_reg;
    logic [IDX_W-1:0] cidx_next;
    logic             busy;
    logic             take_own;

    assign busy     = (slot_reg.pri != 8'd0);
    assign take_own = busy && (!carry_in.found || (slot_reg.pri < carry_in.job.pri));

    always_comb
    begin
        slot_next = slot_reg;
        if (ctrl.enq && !busy && left_busy)
        begin
            slot_next = new_job;
        end
        else if (ctrl.shift && (IDX_W'(CELL_IDX) >= sel_idx))
        begin
            slot_next = right_slot;
        end

        if (take_own)
        begin
            carry_next.found = 1'b1;
            carry_next.job   = slot_reg;
            cidx_next        = IDX_W'(CELL_IDX);
        end
        else
        begin
            carry_next = carry_in;
            cidx_next  = carry_idx_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= '0;
            carry_reg <= '0;
            cidx_reg  <= '0;
        end
        else
        begin
            slot_reg  <= slot_next;
            carry_reg <= carry_next;
            cidx_reg  <= cidx_next;
        end
    end

    assign carry_out     = carry_reg;
    assign carry_idx_out = cidx_reg;
    assign slot          = slot_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/min_priority_job_queue.sv =====
// Top level of the min-priority job queue: sequencer, output register and
// the row of mpjq_cell slots. Depends on mpjq_pkg and mpjq_cell.
//
// Usage:
//   Request channel: in_valid / in_stall with req_type, in_priority, in_pid,
//   in_job_id. Result channel: out_valid / out_stall with status,
//   out_priority, out_pid, out_job_id, occupancy. One result per request.
//   Enqueue, and dequeue or peek on an empty queue: the result is in the
//   output register at the edge after the transfer.
//   Dequeue and peek on a held queue run a minimum search that travels
//   one cell per cycle along the row of QUEUE_DEPTH slots and is read at
//   the end of the row; a dequeue then shifts the later slots down in
//   the same cycle as loading the result.
//   One request is in flight at a time; in_stall is high during the search
//   and while a result waits in the output register under out_stall.
//   When out_stall holds a result, the block keeps it and the next request
//   waits. Reset empties all slots and clears out_valid.
`default_nettype none

module min_priority_job_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire  [1:0]  req_type,
    input  wire  [7:0]  in_priority,
    input  wire  [15:0] in_pid,
    input  wire  [15:0] in_job_id,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [1:0]  status,
    output logic [7:0]  out_priority,
    output logic [15:0] out_pid,
    output logic [15:0] out_job_id,
    output logic [4:0]  occupancy
);
    import mpjq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] held_reg;
    logic [CNT_W-1:0] held_next;
    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] cnt_next;
    logic             deq_reg;
    logic             deq_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [1:0]       status_reg;
    logic [1:0]       status_next;
    slot_t            res_reg;
    slot_t            res_next;
    logic [4:0]       occ_reg;
    logic [4:0]       occ_next;

    cell_ctrl_t       ctrl;
    slot_t            new_job;
    logic             accept;
    logic             out_free;
    logic             full;

    slot_t            slot_w   [QUEUE_DEPTH+1];
    carry_t           carry_w  [QUEUE_DEPTH+1];
    logic [IDX_W-1:0] cidx_w   [QUEUE_DEPTH+1];
    logic             lbusy_w  [QUEUE_DEPTH];

    assign slot_w[QUEUE_DEPTH] = '0;
    assign carry_w[0]          = '0;
    assign cidx_w[0]           = '0;
    assign new_job             = '{pri: in_priority, pid: in_pid, job_id: in_job_id};

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign lbusy_w[i] = 1'b1;
        end
        else
        begin : g_rest
            assign lbusy_w[i] = (slot_w[i-1].pri != 8'd0);
        end

        mpjq_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (i)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctrl          (ctrl),
            .new_job       (new_job),
            .left_busy     (lbusy_w[i]),
            .right_slot    (slot_w[i+1]),
            .sel_idx       (cidx_w[QUEUE_DEPTH]),
            .carry_in      (carry_w[i]),
            .carry_idx_in  (cidx_w[i]),
            .carry_out     (carry_w[i+1]),
            .carry_idx_out (cidx_w[i+1]),
            .slot          (slot_w[i])
        );
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;
    assign full     = (held_reg == CNT_W'(QUEUE_DEPTH));

    always_comb
    begin
        state_next     = state_reg;
        held_next      = held_reg;
        cnt_next       = cnt_reg;
        deq_next       = deq_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        res_next       = res_reg;
        occ_next       = occ_reg;
        ctrl           = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == REQ_ENQ)
                    begin
                        out_valid_next = 1'b1;
                        res_next       = '0;
                        if (full)
                        begin
                            status_next = STATUS_FULL;
                        end
                        else if (in_priority == 8'd0)
                        begin
                            status_next = STATUS_ZERO;
                        end
                        else
                        begin
                            status_next = STATUS_OK;
                            ctrl.enq    = 1'b1;
                            held_next   = held_reg + CNT_W'(1);
                        end
                        occ_next = 5'(held_next);
                    end
                    else if (held_reg == '0)
                    begin
                        out_valid_next = 1'b1;
                        res_next       = '0;
                        status_next    = STATUS_EMPTY;
                        occ_next       = '0;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                        cnt_next   = '0;
                        deq_next   = (req_type == REQ_DEQ);
                    end
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg != IDX_W'(QUEUE_DEPTH - 1))
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = STATUS_OK;
                    res_next       = carry_w[QUEUE_DEPTH].job;
                    if (deq_reg)
                    begin
                        ctrl.shift = 1'b1;
                        held_next  = held_reg - CNT_W'(1);
                    end
                    occ_next   = 5'(held_next);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            held_reg      <= '0;
            cnt_reg       <= '0;
            deq_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            cnt_reg       <= cnt_next;
            deq_reg       <= deq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        res_reg    <= res_next;
        occ_reg    <= occ_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_priority = res_reg.pri;
    assign out_pid      = res_reg.pid;
    assign out_job_id   = res_reg.job_id;
    assign occupancy    = occ_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/mpjq_checker.sv =====
// Port-level checks for min_priority_job_queue, bound to the top level.
// Depends on mpjq_pkg.
`default_nettype none

module mpjq_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        in_valid,
    input wire        in_stall,
    input wire [1:0]  req_type,
    input wire        out_valid,
    input wire        out_stall,
    input wire [1:0]  status,
    input wire [7:0]  out_priority,
    input wire [15:0] out_pid,
    input wire [15:0] out_job_id,
    input wire [4:0]  occupancy
);
    import mpjq_pkg::*;

    // held result (status, pid, job id, occupancy) must not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_pid)
                                   && $stable(out_job_id) && $stable(occupancy))
        else $error("result changed under stall");

    a_reject_blank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STATUS_OK) |->
            (out_priority == 8'd0) && (out_pid == 16'd0) && (out_job_id == 16'd0))
        else $error("rejected result carries a job");

    a_enq_immediate: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (req_type == REQ_ENQ) |=>
            out_valid && (out_priority == 8'd0) && (status != STATUS_EMPTY))
        else $error("enqueue result missing or wrong");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_EMPTY) |-> (occupancy == 5'd0))
        else $error("empty status with nonzero occupancy");

endmodule

bind min_priority_job_queue mpjq_checker u_mpjq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .out_priority (out_priority),
    .out_pid      (out_pid),
    .out_job_id   (out_job_id),
    .occupancy    (occupancy)
);

`default_nettype wire
